@@ hdl/kmnca_pkg.sv @@
// Package: types, sizes and codes shared by the k-means assignment block.
package kmnca_pkg;

    localparam int MaxClusters = 16;
    localparam int MaxFeatures = 16;
    localparam int CIdxW = $clog2(MaxClusters);
    localparam int FIdxW = $clog2(MaxFeatures);
    localparam int CCntW = $clog2(MaxClusters + 1);
    localparam int FCntW = $clog2(MaxFeatures + 1);
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 5;

    localparam logic [CfgIdxW-1:0] CfgClusters = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgFeatures = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgUpdate = 2'd2;

    typedef enum logic [1:0] {
        KIND_CENTER = 2'd0,
        KIND_FEATURE = 2'd1,
        KIND_READ = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_WSUM,
        ST_CSUM,
        ST_READ,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] cluster_index;
        logic [3:0] feature_index;
        logic signed [15:0] coord_value;
        logic [15:0] weight;
        logic last_feature;
    } in_item_t;

    typedef struct packed {
        logic result_kind;
        logic [3:0] label;
        logic signed [47:0] coord_sum;
        logic [47:0] weight_sum;
    } out_item_t;

endpackage

@@ hdl/kmeans_nearest_center_accumulate_top.sv @@
// Top level: k-means nearest-center search with per-cluster weighted accumulation.
// Busy from input to result transfer: a readback reads one element; a last feature
// walks all centers, then with update on adds to the winner's sums; a clear walks all
// clusters. Center writes and other features leave it idle. One shared subtract/
// square/accumulate unit walks the center store one element per cycle. No stall.
// Reset clears the control state and the accumulator valid bits, counts go to 16.
module kmeans_nearest_center_accumulate_top (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  kmnca_pkg::in_item_t in_item,
    output logic result_valid,
    output kmnca_pkg::out_item_t result,
    input  logic cfg_we,
    input  logic [kmnca_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [kmnca_pkg::CfgDataW-1:0] cfg_data
);

    localparam int CIW = kmnca_pkg::CIdxW;
    localparam int FIW = kmnca_pkg::FIdxW;
    localparam int NC = kmnca_pkg::MaxClusters;
    localparam int NF = kmnca_pkg::MaxFeatures;
    localparam logic signed [47:0] S48Max = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] S48Min = {1'b1, {47{1'b0}}};

    // memories
    logic signed [15:0] center_mem [NC*NF];
    logic signed [47:0] coord_mem [NC*NF];
    logic signed [15:0] sample_reg [NF];
    logic [47:0] wacc_reg [NC];
    logic [NC*NF-1:0] cvalid_reg;
    logic [NC-1:0] wvalid_reg;

    // config
    logic [4:0] ncl_reg, nft_reg;
    logic upd_reg;
    logic [CIW-1:0] nc_last;
    logic [FIW-1:0] nf_last;

    kmnca_pkg::state_t state_reg, state_next;
    logic [CIW-1:0] c_reg;
    logic [FIW-1:0] f_reg;
    logic [CIW-1:0] best_reg;
    logic [36:0] d_reg, best_d_reg;
    logic [15:0] w_reg;
    logic [CIW-1:0] rc_reg;
    logic [FIW-1:0] rf_reg;
    logic rok_reg;
    logic signed [15:0] cen_q;
    logic signed [47:0] cacc_q;
    logic pipe_reg;          // center read data valid
    logic [FIW-1:0] pf_reg;  // feature of registered read
    logic [CIW-1:0] pc_reg;
    logic plast_f, plast_c;
    logic plf_reg, plc_reg;

    logic accept;
    logic [FIW-1:0] in_f;
    logic [CIW-1:0] in_c;

    assign accept = start && !busy;
    assign in_f = in_item.feature_index[FIW-1:0];
    assign in_c = in_item.cluster_index[CIW-1:0];
    assign nc_last = (ncl_reg == 5'd0) ? '0 :
                     (ncl_reg > 5'(NC)) ? CIW'(NC - 1) : CIW'(ncl_reg - 5'd1);
    assign nf_last = (nft_reg == 5'd0) ? '0 :
                     (nft_reg > 5'(NF)) ? FIW'(NF - 1) : FIW'(nft_reg - 5'd1);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncl_reg <= 5'd16;
            nft_reg <= 5'd16;
            upd_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kmnca_pkg::CfgClusters: ncl_reg <= cfg_data;
                kmnca_pkg::CfgFeatures: nft_reg <= cfg_data;
                kmnca_pkg::CfgUpdate: upd_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kmnca_pkg::ST_IDLE:
                if (accept)
                begin
                    unique case (kmnca_pkg::kind_t'(in_item.kind))
                        kmnca_pkg::KIND_CENTER: state_next = kmnca_pkg::ST_IDLE;
                        kmnca_pkg::KIND_FEATURE:
                            state_next = in_item.last_feature ? kmnca_pkg::ST_DIST
                                                              : kmnca_pkg::ST_IDLE;
                        kmnca_pkg::KIND_READ: state_next = kmnca_pkg::ST_READ;
                        kmnca_pkg::KIND_CLEAR: state_next = kmnca_pkg::ST_CLEAR;
                        default: state_next = kmnca_pkg::ST_IDLE;
                    endcase
                end
            kmnca_pkg::ST_DIST:
                if (pipe_reg && plast_f && plast_c)
                    state_next = upd_reg ? kmnca_pkg::ST_WSUM : kmnca_pkg::ST_DONE;
            kmnca_pkg::ST_WSUM: state_next = kmnca_pkg::ST_CSUM;
            kmnca_pkg::ST_CSUM:
                if (pipe_reg && plast_f) state_next = kmnca_pkg::ST_DONE;
            kmnca_pkg::ST_READ: if (pipe_reg) state_next = kmnca_pkg::ST_IDLE;
            kmnca_pkg::ST_CLEAR: if (c_reg == CIW'(NC - 1)) state_next = kmnca_pkg::ST_IDLE;
            kmnca_pkg::ST_DONE: state_next = kmnca_pkg::ST_IDLE;
            default: state_next = kmnca_pkg::ST_IDLE;
        endcase
    end

    // outputs: readback once its data is registered, label in the done cycle
    always_comb
    begin
        busy = (state_reg != kmnca_pkg::ST_IDLE);
        result_valid = (state_reg == kmnca_pkg::ST_READ && pipe_reg) ||
                       (state_reg == kmnca_pkg::ST_DONE);
    end

    assign plast_f = plf_reg;
    assign plast_c = plc_reg;

    // squared distance of the element in the read register
    logic signed [16:0] diff;
    logic [33:0] sq;
    logic [36:0] d_new;
    logic better;
    assign diff = 17'(sample_reg[pf_reg]) - 17'(cen_q);
    assign sq = 34'($signed(diff) * $signed(diff));
    assign d_new = ((pf_reg == '0) ? 37'd0 : d_reg) + 37'(sq);
    assign better = (pc_reg == '0) || (d_new < best_d_reg);

    // weighted coordinate update
    logic signed [32:0] prod;
    logic signed [48:0] csum;
    logic signed [47:0] csat;
    logic signed [47:0] cacc_eff;
    logic [48:0] wsum;
    assign cacc_eff = cvalid_reg[{pc_reg, pf_reg}] ? cacc_q : 48'sd0;
    assign prod = 33'(sample_reg[pf_reg]) * $signed({1'b0, w_reg});
    assign csum = 49'(cacc_eff) + 49'(prod);
    assign csat = (csum > 49'(S48Max)) ? S48Max :
                  (csum < 49'(S48Min)) ? S48Min : csum[47:0];
    assign wsum = (wvalid_reg[best_reg] ? {1'b0, wacc_reg[best_reg]} : 49'd0) + 49'(w_reg);

    // memory reads, one element a cycle
    always_ff @(posedge clk)
    begin
        cen_q <= center_mem[{c_reg, f_reg}];
        cacc_q <= coord_mem[{c_reg, f_reg}];
        pf_reg <= f_reg;
        pc_reg <= c_reg;
        plf_reg <= (f_reg == nf_last);
        plc_reg <= (state_reg == kmnca_pkg::ST_CSUM) || (c_reg == nc_last);
        if (accept && kmnca_pkg::kind_t'(in_item.kind) == kmnca_pkg::KIND_CENTER)
            center_mem[{in_c, in_f}] <= in_item.coord_value;
        if (state_reg == kmnca_pkg::ST_CSUM && pipe_reg)
            coord_mem[{pc_reg, pf_reg}] <= csat;
    end

    // datapath and sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kmnca_pkg::ST_IDLE;
            pipe_reg <= 1'b0;
            cvalid_reg <= '0;
            wvalid_reg <= '0;
            c_reg <= '0;
            f_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // data read in a walking state is valid in the following cycle
            pipe_reg <= (state_reg == kmnca_pkg::ST_DIST) ||
                        (state_reg == kmnca_pkg::ST_READ) ||
                        (state_reg == kmnca_pkg::ST_CSUM);
            if (accept)
            begin
                if (kmnca_pkg::kind_t'(in_item.kind) == kmnca_pkg::KIND_FEATURE)
                begin
                    sample_reg[in_f] <= in_item.coord_value;
                    w_reg <= in_item.weight;
                end
                if (kmnca_pkg::kind_t'(in_item.kind) == kmnca_pkg::KIND_READ)
                begin
                    c_reg <= in_c;
                    f_reg <= in_f;
                    rc_reg <= in_c;
                    rf_reg <= in_f;
                    rok_reg <= 1'b1;
                end
                else
                begin
                    c_reg <= '0;
                    f_reg <= '0;
                end
            end
            unique case (state_reg)
                kmnca_pkg::ST_DIST:
                begin
                    if (pipe_reg)
                    begin
                        d_reg <= d_new;
                        if (plast_f && better)
                        begin
                            best_d_reg <= d_new;
                            best_reg <= pc_reg;
                        end
                    end
                    if (f_reg == nf_last)
                    begin
                        f_reg <= '0;
                        c_reg <= c_reg + 1'b1;
                    end
                    else
                        f_reg <= f_reg + 1'b1;
                end
                kmnca_pkg::ST_WSUM:
                begin
                    wacc_reg[best_reg] <= wsum[48] ? {48{1'b1}} : wsum[47:0];
                    wvalid_reg[best_reg] <= 1'b1;
                    c_reg <= best_reg;
                    f_reg <= '0;
                end
                kmnca_pkg::ST_CSUM:
                begin
                    if (pipe_reg)
                        cvalid_reg[{pc_reg, pf_reg}] <= 1'b1;
                    if (f_reg != nf_last)
                        f_reg <= f_reg + 1'b1;
                end
                kmnca_pkg::ST_CLEAR:
                begin
                    cvalid_reg[c_reg*NF +: NF] <= '0;
                    wvalid_reg[c_reg] <= 1'b0;
                    c_reg <= c_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result payload
    always_comb
    begin
        result = '0;
        if (state_reg == kmnca_pkg::ST_READ)
        begin
            result.result_kind = 1'b1;
            result.label = 4'(rc_reg);
            if (rok_reg)
            begin
                result.coord_sum = cvalid_reg[{rc_reg, rf_reg}] ? cacc_q : 48'sd0;
                result.weight_sum = wvalid_reg[rc_reg] ? wacc_reg[rc_reg] : 48'd0;
            end
        end
        else
            result.label = 4'(best_reg);
    end

endmodule

@@ tb/kmeans_nearest_center_accumulate_top_test.sv @@
// Testbench: directed table and random samples for the k-means assignment block.
module kmeans_nearest_center_accumulate_top_test;

    typedef struct {
        kmnca_pkg::in_item_t   item;
        bit                    typed;
        kmnca_pkg::out_item_t  want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    kmnca_pkg::in_item_t in_item = '0;
    logic result_valid;
    kmnca_pkg::out_item_t result;
    logic cfg_we = 1'b0;
    logic [kmnca_pkg::CfgIdxW-1:0] cfg_index = '0;
    logic [kmnca_pkg::CfgDataW-1:0] cfg_data = '0;

    // Shadow state of the block
    logic signed [15:0] center_mem [kmnca_pkg::MaxClusters][kmnca_pkg::MaxFeatures];
    logic signed [15:0] sample_mem [kmnca_pkg::MaxFeatures];
    longint coord_acc [kmnca_pkg::MaxClusters][kmnca_pkg::MaxFeatures];
    longint unsigned weight_acc [kmnca_pkg::MaxClusters];
    logic [4:0] nc_reg;
    logic [4:0] nf_reg;
    logic upd_reg;

    kmnca_pkg::out_item_t pending_results[$];
    int errors = 0;
    int idle_pct = 0;
    stim_row_t table_rows[$];

    kmeans_nearest_center_accumulate_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .result_valid(result_valid), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int clamp_cnt(logic [4:0] v);
        if (v == 0)
            return 1;
        if (v > 16)
            return 16;
        return int'(v);
    endfunction

    function automatic kmnca_pkg::in_item_t mk(kmnca_pkg::kind_t k, int ci, int fi, int cv,
                                               int w, bit last);
        kmnca_pkg::in_item_t it;
        it.kind = k;
        it.cluster_index = ci[3:0];
        it.feature_index = fi[3:0];
        it.coord_value = cv[15:0];
        it.weight = w[15:0];
        it.last_feature = last;
        return it;
    endfunction

    // Nearest-center search and accumulation; returns 1 when a result is due
    function automatic bit assign_and_accumulate(kmnca_pkg::in_item_t it,
                                                 output kmnca_pkg::out_item_t r);
        int nc, nf, best;
        longint unsigned d, best_d, w;
        longint diff, s;
        r = '0;
        case (kmnca_pkg::kind_t'(it.kind))
            kmnca_pkg::KIND_CENTER:
            begin
                center_mem[it.cluster_index][it.feature_index] = it.coord_value;
                return 0;
            end
            kmnca_pkg::KIND_CLEAR:
            begin
                foreach (weight_acc[c])
                begin
                    weight_acc[c] = 0;
                    for (int f = 0; f < kmnca_pkg::MaxFeatures; f++)
                        coord_acc[c][f] = 0;
                end
                return 0;
            end
            kmnca_pkg::KIND_READ:
            begin
                r.result_kind = 1'b1;
                r.label = it.cluster_index;
                r.coord_sum = coord_acc[it.cluster_index][it.feature_index][47:0];
                r.weight_sum = weight_acc[it.cluster_index][47:0];
                return 1;
            end
            default:
            begin
                sample_mem[it.feature_index] = it.coord_value;
                if (!it.last_feature)
                    return 0;
                nc = clamp_cnt(nc_reg);
                nf = clamp_cnt(nf_reg);
                best = 0;
                best_d = 0;
                for (int c = 0; c < nc; c++)
                begin
                    d = 0;
                    for (int f = 0; f < nf; f++)
                    begin
                        diff = longint'(sample_mem[f]) - longint'(center_mem[c][f]);
                        d += longint'(diff * diff);
                    end
                    if (c == 0 || d < best_d)
                    begin
                        best_d = d;
                        best = c;
                    end
                end
                if (upd_reg)
                begin
                    w = weight_acc[best] + it.weight;
                    weight_acc[best] = (w > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : w;
                    for (int f = 0; f < nf; f++)
                    begin
                        s = coord_acc[best][f]
                            + longint'(sample_mem[f]) * longint'({1'b0, it.weight});
                        if (s > 64'sh7FFF_FFFF_FFFF)
                            s = 64'sh7FFF_FFFF_FFFF;
                        if (s < -64'sh8000_0000_0000)
                            s = -64'sh8000_0000_0000;
                        coord_acc[best][f] = s;
                    end
                end
                r.result_kind = 1'b0;
                r.label = best[3:0];
                return 1;
            end
        endcase
    endfunction

    // One transfer; start stays high across back-to-back items unless a random idle gap comes between them
    task automatic send(kmnca_pkg::in_item_t it, bit typed = 0,
                        kmnca_pkg::out_item_t want = '0);
        kmnca_pkg::out_item_t r;
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (assign_and_accumulate(it, r))
            pending_results.push_back(typed ? want : r);
    endtask

    task automatic write_cfg(int clusters, int features, bit upd);
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= kmnca_pkg::CfgClusters;
        cfg_data <= clusters[4:0];
        @(posedge clk);
        nc_reg = clusters[4:0];
        cfg_index <= kmnca_pkg::CfgFeatures;
        cfg_data <= features[4:0];
        @(posedge clk);
        nf_reg = features[4:0];
        cfg_index <= kmnca_pkg::CfgUpdate;
        cfg_data <= {4'b0, upd};
        @(posedge clk);
        upd_reg = upd;
        cfg_we <= 1'b0;
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0: return 32767;
            1: return -32768;
            2: return 256 * $urandom_range(0, 4) - 512;
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int rand_weight();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 65535;
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        kmnca_pkg::out_item_t e;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: %p", result);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (result.result_kind !== e.result_kind)
                begin
                    $error("result_kind: expected %0d, got %0d",
                           e.result_kind, result.result_kind);
                    errors++;
                end
                if (result.label !== e.label)
                begin
                    $error("label: expected %0d, got %0d", e.label, result.label);
                    errors++;
                end
                if (result.coord_sum !== e.coord_sum)
                begin
                    $error("coord_sum: expected %0d, got %0d",
                           e.coord_sum, result.coord_sum);
                    errors++;
                end
                if (result.weight_sum !== e.weight_sum)
                begin
                    $error("weight_sum: expected %0d, got %0d",
                           e.weight_sum, result.weight_sum);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        kmnca_pkg::out_item_t zero_rd;
        int nf, items, waited;
        int phase_nc [8] = '{16, 1, 4, 0, 31, 16, 2, 17};
        int phase_nf [8] = '{16, 1, 3, 0, 31, 1, 16, 5};
        bit phase_up [8] = '{1, 1, 0, 1, 1, 1, 0, 1};
        int phase_idle [4] = '{0, 78, 0, 33};

        foreach (weight_acc[c])
        begin
            weight_acc[c] = 0;
            for (int f = 0; f < kmnca_pkg::MaxFeatures; f++)
                coord_acc[c][f] = 0;
        end
        nc_reg = 16;
        nf_reg = 16;
        upd_reg = 1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every center and sample entry before any search reads them
        for (int c = 0; c < kmnca_pkg::MaxClusters; c++)
            for (int f = 0; f < kmnca_pkg::MaxFeatures; f++)
                send(mk(kmnca_pkg::KIND_CENTER, c, f, rand_coord(), 0, 0));
        for (int f = 0; f < kmnca_pkg::MaxFeatures; f++)
            send(mk(kmnca_pkg::KIND_FEATURE, 0, f, rand_coord(), 0, 0));

        // Directed table
        zero_rd = '0;
        zero_rd.result_kind = 1'b1;
        table_rows.push_back('{mk(kmnca_pkg::KIND_READ, 0, 0, 0, 0, 0), 1, zero_rd});
        zero_rd.label = 4'd15;
        table_rows.push_back('{mk(kmnca_pkg::KIND_READ, 15, 15, 0, 0, 0), 1, zero_rd});
        table_rows.push_back('{mk(kmnca_pkg::KIND_FEATURE, 0, 15, 32767, 0, 0), 0, '0});
        table_rows.push_back('{mk(kmnca_pkg::KIND_FEATURE, 0, 0, 32767, 65535, 1), 0, '0});
        table_rows.push_back('{mk(kmnca_pkg::KIND_FEATURE, 0, 0, -32768, 0, 1), 0, '0});
        table_rows.push_back('{mk(kmnca_pkg::KIND_CENTER, 3, 0, -32768, 0, 0), 0, '0});
        table_rows.push_back('{mk(kmnca_pkg::KIND_CENTER, 15, 15, 32767, 0, 0), 0, '0});
        table_rows.push_back('{mk(kmnca_pkg::KIND_FEATURE, 1, 7, -32768, 65535, 1), 0, '0});
        table_rows.push_back('{mk(kmnca_pkg::KIND_FEATURE, 9, 3, 32767, 1, 1), 0, '0});
        for (int c = 0; c < 4; c++)
            table_rows.push_back('{mk(kmnca_pkg::KIND_READ, c * 5, c * 5, 0, 0, 0), 0, '0});
        table_rows.push_back('{mk(kmnca_pkg::KIND_CLEAR, 0, 0, 0, 0, 0), 0, '0});
        zero_rd.label = 4'd5;
        table_rows.push_back('{mk(kmnca_pkg::KIND_READ, 5, 2, 0, 0, 0), 1, zero_rd});
        table_rows.push_back('{mk(kmnca_pkg::KIND_FEATURE, 2, 2, 0, 65535, 1), 0, '0});
        table_rows.push_back('{mk(kmnca_pkg::KIND_READ, 0, 2, 0, 0, 0), 0, '0});
        foreach (table_rows[i])
            send(table_rows[i].item, table_rows[i].typed, table_rows[i].want);

        // Random phases: one setting and one idling level each
        items = 0;
        for (int p = 0; p < 8; p++)
        begin
            if (p == 7)
                write_cfg($urandom_range(0, 31), $urandom_range(0, 31),
                          1'($urandom_range(0, 1)));
            else
                write_cfg(phase_nc[p], phase_nf[p], phase_up[p]);
            idle_pct = phase_idle[p % 4];
            nf = clamp_cnt(nf_reg);
            items = 0;
            while (items < 195)
            begin
                case ($urandom_range(0, 19))
                    0, 1:
                    begin
                        send(mk(kmnca_pkg::KIND_CENTER, $urandom_range(0, 15),
                                $urandom_range(0, 15), rand_coord(), rand_weight(),
                                1'($urandom_range(0, 1))));
                        items++;
                    end
                    2, 3:
                    begin
                        send(mk(kmnca_pkg::KIND_READ, $urandom_range(0, 15),
                                $urandom_range(0, 15), rand_coord(), rand_weight(),
                                1'($urandom_range(0, 1))));
                        items++;
                    end
                    4:
                    begin
                        if ($urandom_range(0, 7) == 0)
                            send(mk(kmnca_pkg::KIND_CLEAR, $urandom_range(0, 15),
                                    $urandom_range(0, 15), rand_coord(), rand_weight(),
                                    1'($urandom_range(0, 1))));
                        else
                            send(mk(kmnca_pkg::KIND_FEATURE, 0, $urandom_range(0, 15),
                                    rand_coord(), rand_weight(), 1'($urandom_range(0, 1))));
                        items++;
                    end
                    default:
                    begin
                        // well-formed sample: features in order, last one flagged
                        for (int f = 0; f < nf; f++)
                            send(mk(kmnca_pkg::KIND_FEATURE, $urandom_range(0, 15), f,
                                    rand_coord(), rand_weight(), f == nf - 1));
                        items += nf;
                    end
                endcase
            end
        end

        start <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (300) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/kmnca_pkg.sv
hdl/kmeans_nearest_center_accumulate_top.sv
tb/kmeans_nearest_center_accumulate_top_test.sv
